// File: rtl/wss_pkg.sv
// Package for the windowed substring search unit.
// Word kind codes, field widths and the control word shared by the matcher cells.
// No dependencies.
package wss_pkg;

  localparam int POS_W      = 31;  // match position and config register width
  localparam int TPOS_W     = 32;  // text position counter width
  localparam int BYTE_W     = 8;
  localparam int OUT_DATA_W = 32;  // match_position padded to whole bytes

  localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
  localparam logic [TPOS_W-1:0] TPOS_MAX = {TPOS_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_START_OFFSET = 1'b0,
    CFG_END_LIMIT    = 1'b1
  } cfg_idx_t;

  // Broadcast to every cell in the row each cycle.
  typedef struct packed {
    logic              restart;  // clear the prefix bit
    logic              text_en;  // advance the prefix bit with a text byte
    logic              load;     // write a pattern byte into the selected cell
    logic [BYTE_W-1:0] data;
  } cell_ctl_t;

endpackage

// File: rtl/wss_cell.sv
// One matcher cell: holds a pattern byte and one bit of the prefix match vector.
// Depends on wss_pkg.
module wss_cell
  import wss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      load_sel,  // this cell is the next free pattern slot
  input  logic      active,    // this cell lies inside the loaded pattern
  input  logic      prev_i,    // prefix bit of the left neighbor
  output logic      match_o,   // new prefix bit for the current text byte
  output logic      bit_o      // stored prefix bit, to the right neighbor
);

  logic [BYTE_W-1:0] pat_r;
  logic              bit_r;
  logic              bit_nxt;

  assign match_o = prev_i & active & (pat_r == ctl.data);
  assign bit_o   = bit_r;

  always_comb begin
    bit_nxt = bit_r;
    if (ctl.restart) begin
      bit_nxt = 1'b0;
    end else if (ctl.text_en) begin
      bit_nxt = match_o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && load_sel) begin
      pat_r <= ctl.data;
    end
  end

endmodule

// File: rtl/windowed_substring_search_unit.sv
// Top level of the windowed substring search unit.
// Instantiates a row of wss_cell matchers; depends on wss_pkg.
//
// Usage:
//   Input stream (in_*): each word is a clear-pattern, append-pattern-byte or
//   text-byte command, chosen by in_tuser. in_tdata carries the byte, in_tlast
//   marks the final byte of a text (ignored on pattern words).
//   Output stream (out_*): one result word per text, either at the first match
//   that lies inside the window [start_offset, end_limit) or at the last text
//   byte with found = 0. Later bytes of a text already matched give nothing.
//   Config port (cfg_*): start_offset at index 0, end_limit at index 1; write
//   only while the block is idle.
// Latency and throughput:
//   One word per cycle while in_tready is high. A result appears on out_*
//   the cycle after the text byte that causes it is accepted. The prefix
//   vector is spread over MAX_PATTERN cells, each updating its bit from its
//   neighbor, so the search rate does not depend on pattern length.
// Reset:
//   Synchronous, active low. Clears pattern length, overflow flag, prefix
//   vector, text position and both config registers. Pattern bytes are not
//   cleared; only loaded bytes are ever compared.
// Backpressure:
//   A single output register decouples the sides. in_tready drops only while a
//   result is held and out_tready is low.
module windowed_substring_search_unit
  import wss_pkg::*;
#(
  parameter int MAX_PATTERN = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] data_byte
  input  logic [1:0]            in_tuser,   // [1:0] kind
  input  logic                  in_tlast,   // last_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [30:0] match_position, [31] zero
  output logic                  out_tuser,  // [0] found
  // config write port
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [POS_W-1:0]      cfg_wdata
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // config registers
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] end_r, end_nxt;

  // pattern and text state
  logic [LW-1:0]     len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              done_r, done_nxt;
  logic [TPOS_W-1:0] tpos_r, tpos_nxt;     // position of the current byte
  logic [TPOS_W:0]   tpos1_r, tpos1_nxt;   // same plus one, end-exclusive

  // output register
  logic                  ovalid_r, ovalid_nxt;
  logic                  ofound_r, ofound_nxt;
  logic [POS_W-1:0]      opos_r, opos_nxt;

  logic      accept;
  kind_t     kind;
  cell_ctl_t ctl;

  logic [MAX_PATTERN-1:0] cell_match;
  logic [MAX_PATTERN-1:0] cell_bit;
  logic [MAX_PATTERN-1:0] last_sel;

  logic             pat_hit;
  logic             hit;
  logic             text_acc;
  logic [TPOS_W:0]  begin_w;
  logic [POS_W-1:0] begin_pos;

  assign accept    = in_tvalid && in_tready;
  assign kind      = kind_t'(in_tuser);
  assign in_tready = !ovalid_r || out_tready;
  assign text_acc  = accept && (kind == KIND_TEXT);

  assign ctl.restart = accept && ((kind == KIND_CLEAR) || (kind == KIND_APPEND) ||
                                  ((kind == KIND_TEXT) && in_tlast));
  assign ctl.text_en = text_acc && !done_r;
  assign ctl.load    = accept && (kind == KIND_APPEND) && !ovf_r &&
                       (len_r < LW'(MAX_PATTERN));
  assign ctl.data    = in_tdata;

  // row of matcher cells; cell 0 always sees a set left neighbor
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = cell_bit[k-1];
    end
    assign last_sel[k] = (len_r == LW'(k + 1));

    wss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_sel (len_r == LW'(k)),
      .active   ((LW'(k) < len_r) && !ovf_r),
      .prev_i   (prev),
      .match_o  (cell_match[k]),
      .bit_o    (cell_bit[k])
    );
  end

  // full pattern matched when the bit of its last byte is set
  assign pat_hit = |(cell_match & last_sel);
  assign begin_w = tpos1_r - (TPOS_W + 1)'(len_r);

  always_comb begin
    hit       = 1'b0;
    begin_pos = begin_w[POS_W-1:0];
    if (ovf_r || done_r) begin
      hit = 1'b0;
    end else if (len_r == '0) begin
      // empty pattern: hit on the byte at start_offset
      begin_pos = start_r;
      hit = (tpos_r == TPOS_W'(start_r)) && ((end_r == '0) || (start_r <= end_r));
    end else begin
      hit = pat_hit &&
            (tpos1_r >= (TPOS_W + 1)'(len_r)) &&
            (begin_w >= (TPOS_W + 1)'(start_r)) &&
            (begin_w <= (TPOS_W + 1)'(POS_MAX)) &&
            ((end_r == '0) || (tpos1_r <= (TPOS_W + 1)'(end_r)));
    end
  end

  // config writes
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_OFFSET: start_nxt = cfg_wdata;
        CFG_END_LIMIT:    end_nxt   = cfg_wdata;
      endcase
    end
  end

  // pattern, text and output control
  always_comb begin
    len_nxt    = len_r;
    ovf_nxt    = ovf_r;
    done_nxt   = done_r;
    tpos_nxt   = tpos_r;
    tpos1_nxt  = tpos1_r;
    ovalid_nxt = ovalid_r;
    ofound_nxt = ofound_r;
    opos_nxt   = opos_r;

    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end

    if (accept) begin
      unique case (kind)
        KIND_CLEAR: begin
          len_nxt   = '0;
          ovf_nxt   = 1'b0;
          done_nxt  = 1'b0;
          tpos_nxt  = '0;
          tpos1_nxt = (TPOS_W + 1)'(1);
        end
        KIND_APPEND: begin
          if (ctl.load) begin
            len_nxt = len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          done_nxt  = 1'b0;
          tpos_nxt  = '0;
          tpos1_nxt = (TPOS_W + 1)'(1);
        end
        KIND_TEXT: begin
          if (hit) begin
            ovalid_nxt = 1'b1;
            ofound_nxt = 1'b1;
            opos_nxt   = begin_pos;
          end else if (in_tlast && !done_r) begin
            ovalid_nxt = 1'b1;
            ofound_nxt = 1'b0;
            opos_nxt   = '0;
          end
          if (in_tlast) begin
            done_nxt  = 1'b0;
            tpos_nxt  = '0;
            tpos1_nxt = (TPOS_W + 1)'(1);
          end else begin
            if (hit) begin
              done_nxt = 1'b1;
            end
            // position saturates at all ones
            if (tpos_r != TPOS_MAX) begin
              tpos_nxt  = tpos_r + TPOS_W'(1);
              tpos1_nxt = tpos1_r + (TPOS_W + 1)'(1);
            end
          end
        end
        default: ;  // reserved kind: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= '0;
      len_r    <= '0;
      ovf_r    <= 1'b0;
      done_r   <= 1'b0;
      tpos_r   <= '0;
      tpos1_r  <= (TPOS_W + 1)'(1);
      ovalid_r <= 1'b0;
    end else begin
      start_r  <= start_nxt;
      end_r    <= end_nxt;
      len_r    <= len_nxt;
      ovf_r    <= ovf_nxt;
      done_r   <= done_nxt;
      tpos_r   <= tpos_nxt;
      tpos1_r  <= tpos1_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ofound_r <= ofound_nxt;
    opos_r   <= opos_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ofound_r;
  assign out_tdata  = {{(OUT_DATA_W - POS_W){1'b0}}, opos_r};

endmodule

// File: rtl/wss_checker.sv
// Port-level checker for the windowed substring search unit, bound to the top.
// Depends on wss_pkg.
module wss_checker
  import wss_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a miss always reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero position");

  // input side never stalls while the output register is free
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled with free output register");

endmodule

bind windowed_substring_search_unit wss_checker u_wss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: sim/tb_windowed_substring_search_unit.sv
// Self-checking testbench for the windowed substring search unit.
// Uses wss_pkg and windowed_substring_search_unit. Runs a directed vector table,
// then random pattern/text sequences under several window settings with a predictor.
module tb_windowed_substring_search_unit;
  import wss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD   = 20;
  localparam int          MAX_PATTERN  = 16;
  localparam int          RANDOM_WORDS = 600;
  localparam int          STALL_LIMIT  = 1000;  // cycles with no handshake or config write
  localparam int          HOLD_CYCLES  = 100;   // one long receiver hold-off
  localparam int          SETTLE       = 4;     // result lands the cycle after its word
  localparam logic [1:0]  KIND_IGNORED = 2'd3;  // undefined kind, block drops it

  // One result word: found flag plus match position.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } match_t;

  localparam match_t NO_MATCH = '0;

  // Directed vector: a word, how often it repeats, and optionally a typed-in result.
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             last;
    int               reps;
    bit               typed;    // use the expectation below instead of the predictor
    bit               has_res;
    logic             found;
    logic [POS_W-1:0] pos;
  } vector_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;   // [7:0] data_byte
  logic [1:0]            in_tuser   = '0;   // [1:0] kind
  logic                  in_tlast   = 1'b0; // last_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [30:0] match_position, [31] zero
  logic                  out_tuser;         // [0] found
  logic                  cfg_we     = 1'b0;
  logic                  cfg_index  = 1'b0;
  logic [POS_W-1:0]      cfg_wdata  = '0;

  windowed_substring_search_unit #(.MAX_PATTERN(MAX_PATTERN)) DUT (.*);

  always #(CLK_PERIOD/2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: loaded pattern, prefix vector, text position, window.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]      needle [MAX_PATTERN];
  int                     needle_len      = 0;
  bit                     needle_overflow = 1'b0;
  logic [MAX_PATTERN-1:0] prefix_hits     = '0;
  logic [TPOS_W-1:0]      text_pos        = '0;
  bit                     text_matched    = 1'b0;
  logic [POS_W-1:0]       window_start    = '0;
  logic [POS_W-1:0]       window_end      = '0;

  match_t pending_matches [$];  // results owed by the block, oldest first
  int     words_sent   = 0;     // accepted clear/append/text words
  int     results_seen = 0;
  int     error_count  = 0;
  int     idle_cycles  = 0;
  bit     tx_burst     = 1'b0;  // sender runs without gaps

  function automatic void restart_text();
    prefix_hits  = '0;
    text_pos     = '0;
    text_matched = 1'b0;
  endfunction

  // Advance the predictor by one word; returns 1 when the word owes a result.
  function automatic bit search_step(input logic [1:0] kind, input logic [7:0] data,
                                     input logic last, output match_t res);
    bit                     hit = 1'b0;
    bit                     emit = 1'b0;
    logic [MAX_PATTERN-1:0] eq = '0;
    logic [TPOS_W:0]        match_end;
    logic [TPOS_W:0]        match_begin = '0;
    res = NO_MATCH;
    case (kind)
      KIND_CLEAR: begin
        needle_len      = 0;
        needle_overflow = 1'b0;
        restart_text();
      end
      KIND_APPEND: begin
        if (!needle_overflow && needle_len < MAX_PATTERN) begin
          needle[needle_len] = data;
          needle_len++;
        end else begin
          needle_overflow = 1'b1;
        end
        restart_text();
      end
      KIND_TEXT: begin
        if (!text_matched) begin
          if (needle_overflow) begin
            prefix_hits = '0;
          end else if (needle_len == 0) begin
            // empty pattern hits when the text reaches the window start
            if (text_pos == window_start && (window_end == '0 || window_start <= window_end)) begin
              hit         = 1'b1;
              match_begin = window_start;
            end
          end else begin
            for (int i = 0; i < needle_len; i++) eq[i] = (needle[i] == data);
            prefix_hits = {prefix_hits[MAX_PATTERN-2:0], 1'b1} & eq;
            if (prefix_hits[needle_len-1]) begin
              match_end = {1'b0, text_pos} + 1'b1;
              if (match_end >= needle_len) begin
                match_begin = match_end - needle_len;
                if (match_begin >= window_start && match_begin <= POS_MAX &&
                    (window_end == '0 || match_end <= window_end))
                  hit = 1'b1;
              end
            end
          end
        end
        if (hit) begin
          res  = '{found: 1'b1, pos: match_begin[POS_W-1:0]};
          emit = 1'b1;
        end
        if (text_pos != TPOS_MAX) text_pos++;
        if (last) begin
          if (!hit && !text_matched) begin
            res  = NO_MATCH;
            emit = 1'b1;
          end
          restart_text();
        end else if (hit) begin
          text_matched = 1'b1;
        end
      end
      default: ;  // undefined kind: no state change
    endcase
    return emit;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gap, drive the word, wait for the handshake, then predict.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] kind, input logic [7:0] data, input logic last,
                           input bit typed, input bit typed_has, input match_t typed_res);
    int     gap;
    bit     has_res;
    match_t res;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has_res = search_step(kind, data, last, res);
    if (typed) begin
      has_res = typed_has;
      res     = typed_res;
    end
    if (has_res) pending_matches.push_back(res);
    if (kind != KIND_IGNORED) words_sent++;
  endtask

  // Stop offering and wait until every owed result is out and the block is quiet.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both window registers, back to back; only called while the block is idle.
  task automatic write_window(input logic [POS_W-1:0] start_val, input logic [POS_W-1:0] end_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_OFFSET;
    cfg_wdata <= start_val;
    @(posedge clk);
    cfg_index <= CFG_END_LIMIT;
    cfg_wdata <= end_val;
    @(posedge clk);
    cfg_we       <= 1'b0;
    window_start  = start_val;
    window_end    = end_val;
  endtask

  // Directed vectors, run with the reset window (start 0, no end limit).
  vector_t directed_vectors [20] = '{
    // empty pattern hits at position 0 on the first byte
    '{KIND_TEXT,    8'h41, 1'b1, 1,  1'b1, 1'b1, 1'b1, 31'd0},
    '{KIND_APPEND,  8'h00, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_APPEND,  8'hFF, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'h00, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'hFF, 1'b0, 1,  1'b1, 1'b1, 1'b1, 31'd0},
    // already matched: last byte owes nothing
    '{KIND_TEXT,    8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b0, 31'd0},
    '{KIND_IGNORED, 8'hFF, 1'b1, 1,  1'b1, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'h5A, 1'b1, 1,  1'b1, 1'b1, 1'b0, 31'd0},
    // tlast on a pattern word is ignored
    '{KIND_APPEND,  8'h00, 1'b1, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'h00, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'hFF, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    // pattern change mid-text drops the partial prefix
    '{KIND_APPEND,  8'h33, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'h00, 1'b1, 1,  1'b1, 1'b1, 1'b0, 31'd0},
    '{KIND_CLEAR,   8'h00, 1'b0, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    // one append past a full pattern sets overflow; nothing matches until a clear
    '{KIND_APPEND,  8'hA5, 1'b0, 17, 1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'hA5, 1'b0, 3,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'hA5, 1'b1, 1,  1'b1, 1'b1, 1'b0, 31'd0},
    '{KIND_CLEAR,   8'hFF, 1'b1, 1,  1'b0, 1'b0, 1'b0, 31'd0},
    '{KIND_TEXT,    8'h00, 1'b0, 1,  1'b1, 1'b1, 1'b1, 31'd0},
    '{KIND_TEXT,    8'hFF, 1'b1, 1,  1'b1, 1'b0, 1'b0, 31'd0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int               base;
    int               phase;
    int               phase_start;
    int               pick;
    int               plen;
    int               ntexts;
    int               tlen;
    logic [7:0]       sym [3];
    logic [7:0]       b;
    logic [POS_W-1:0] start_val;
    logic [POS_W-1:0] end_val;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_vectors[i]) begin
      for (int r = 0; r < directed_vectors[i].reps; r++)
        send_word(directed_vectors[i].kind, directed_vectors[i].data, directed_vectors[i].last,
                  directed_vectors[i].typed, directed_vectors[i].has_res,
                  '{found: directed_vectors[i].found, pos: directed_vectors[i].pos});
    end
    drain();

    // Random part: each phase sets a window, then loads patterns and streams texts.
    base  = words_sent;
    phase = 0;
    while (words_sent - base < RANDOM_WORDS) begin
      case (phase)
        0:       begin start_val = '0;      end_val = '0;      end
        1:       begin start_val = POS_MAX; end_val = '0;      end
        2:       begin start_val = '0;      end_val = POS_MAX; end
        3:       begin start_val = POS_MAX; end_val = POS_MAX; end
        4:       begin start_val = 31'd2;   end_val = '0;      end
        5:       begin start_val = '0;      end_val = 31'd6;   end
        default: begin
          start_val = POS_W'($urandom_range(0, 6));
          end_val   = ($urandom_range(0, 3) == 0) ? '0 : POS_W'($urandom_range(1, 24));
        end
      endcase
      write_window(start_val, end_val);
      tx_burst    = (phase % 4 == 3);
      phase_start = words_sent;

      while (words_sent - phase_start < 60) begin
        foreach (sym[i]) sym[i] = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)      plen = 0;
        else if (pick == 1) plen = $urandom_range(MAX_PATTERN - 1, MAX_PATTERN + 2);
        else                plen = $urandom_range(1, 4);

        send_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, 1'b0, NO_MATCH);
        // long patterns use one symbol so that full-length hits stay likely
        for (int i = 0; i < plen; i++)
          send_word(KIND_APPEND, (plen > 4) ? sym[0] : sym[2'($urandom_range(0, 2))],
                    1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_MATCH);

        ntexts = $urandom_range(1, 3);
        for (int t = 0; t < ntexts; t++) begin
          tlen = $urandom_range(1, plen + 8);
          for (int i = 0; i < tlen; i++) begin
            pick = $urandom_range(0, 119);
            if (pick < 4)
              send_word(KIND_IGNORED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'b0, 1'b0, NO_MATCH);
            else if (pick < 7)
              send_word(KIND_APPEND, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'b0, 1'b0, NO_MATCH);
            else if (pick == 7)
              send_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'b0, 1'b0, NO_MATCH);
            if (plen > 4) b = ($urandom_range(0, 7) == 0) ? sym[1] : sym[0];
            else          b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                          : sym[2'($urandom_range(0, 2))];
            send_word(KIND_TEXT, b, (i == tlen - 1), 1'b0, 1'b0, NO_MATCH);
          end
        end
      end

      // close any open text so the window can change between texts
      if (text_pos != '0)
        send_word(KIND_TEXT, 8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, NO_MATCH);
      drain();
      phase++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per result, one long hold-off to back up the input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= 25) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      // every third block of 40 results goes without stalls
      stall = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_matches.size() == 0) begin
        flag_error($sformatf("unexpected result word found=%0b pos=%0d",
                             out_tuser, out_tdata[POS_W-1:0]));
      end else begin
        want = pending_matches.pop_front();
        if (out_tuser !== want.found)
          flag_error($sformatf("found: expected %0b, got %0b", want.found, out_tuser));
        if (out_tdata[POS_W-1:0] !== want.pos)
          flag_error($sformatf("match_position: expected %0d, got %0d",
                               want.pos, out_tdata[POS_W-1:0]));
        if (out_tdata[OUT_DATA_W-1:POS_W] !== '0)
          flag_error($sformatf("out_tdata pad bit: expected 0, got %0b",
                               out_tdata[OUT_DATA_W-1:POS_W]));
      end
    end
  end

  // Watchdog: any handshake or config write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: windowed_substring_search_unit.f
rtl/wss_pkg.sv
rtl/wss_cell.sv
rtl/windowed_substring_search_unit.sv
rtl/wss_checker.sv
sim/tb_windowed_substring_search_unit.sv
